>>> rtl/core/efhp_pkg.sv
// package for the escaped frame header parser
// types, codes and frame layout constants shared by the core modules; no dependencies

package efhp_pkg;

   // widths of the frame counters
   localparam int POS_W = 11;
   localparam int LEN_W = 10;

   // framing bytes and escape codes
   localparam logic [7:0] FLAG_BYTE   = 8'h7e;
   localparam logic [7:0] ESC_BYTE    = 8'h7d;
   localparam logic [7:0] ESC_CODE_7D = 8'h01;
   localparam logic [7:0] ESC_CODE_7E = 8'h02;

   // properties word bits
   localparam logic [15:0] LEN_MASK  = 16'h03ff;
   localparam logic [15:0] ENC_BIT   = 16'h0400;
   localparam logic [15:0] SPLIT_BIT = 16'h2000;

   // event codes
   localparam logic [1:0] EV_BODY  = 2'd0;
   localparam logic [1:0] EV_GOOD  = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;

   // error codes
   localparam logic [1:0] ERR_ESCAPE    = 2'd0;
   localparam logic [1:0] ERR_CHECKSUM  = 2'd1;
   localparam logic [1:0] ERR_ENCRYPTED = 2'd2;

   // frame positions after the byte is counted (1 is the opening flag)
   localparam logic [POS_W-1:0] POS_HUNT      = 11'd0;
   localparam logic [POS_W-1:0] POS_FIRST     = 11'd1;
   localparam logic [POS_W-1:0] POS_ID_HI     = 11'd2;
   localparam logic [POS_W-1:0] POS_ID_LO     = 11'd3;
   localparam logic [POS_W-1:0] POS_PROPS_HI  = 11'd4;
   localparam logic [POS_W-1:0] POS_PROPS_LO  = 11'd5;
   localparam logic [POS_W-1:0] POS_TERM_0    = 11'd6;
   localparam logic [POS_W-1:0] POS_TERM_1    = 11'd7;
   localparam logic [POS_W-1:0] POS_TERM_2    = 11'd8;
   localparam logic [POS_W-1:0] POS_TERM_3    = 11'd9;
   localparam logic [POS_W-1:0] POS_TERM_4    = 11'd10;
   localparam logic [POS_W-1:0] POS_TERM_5    = 11'd11;
   localparam logic [POS_W-1:0] POS_SERIAL_HI = 11'd12;
   localparam logic [POS_W-1:0] POS_SERIAL_LO = 11'd13;
   localparam logic [POS_W-1:0] POS_TOTAL_HI  = 11'd14;
   localparam logic [POS_W-1:0] POS_TOTAL_LO  = 11'd15;
   localparam logic [POS_W-1:0] POS_INDEX_HI  = 11'd16;
   localparam logic [POS_W-1:0] POS_INDEX_LO  = 11'd17;

   // first position past the header (header length plus flag plus one)
   localparam logic [POS_W-1:0] HDR_SHORT_LIMIT = 11'd14;
   localparam logic [POS_W-1:0] HDR_LONG_LIMIT  = 11'd18;

   // result item
   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  body_byte;
      logic [1:0]  error_code;
      logic [15:0] message_id;
      logic [15:0] message_props;
      logic [47:0] terminal_id;
      logic [15:0] serial_number;
      logic [15:0] packet_total;
      logic [15:0] packet_number;
   } rsp_payload_type;

   // input stage to decoder
   typedef struct packed {
      logic       go;
      logic [7:0] rx_byte;
   } dec_req_type;

   // decoder to output stage
   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } step_type;

endpackage

>>> rtl/core/efhp_if.sv
// valid/ready channel interfaces for the escaped frame header parser
// request carries one raw byte, response carries one parse result; no dependencies

interface efhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [7:0]  body_byte;
   logic [1:0]  error_code;
   logic [15:0] message_id;
   logic [15:0] message_props;
   logic [47:0] terminal_id;
   logic [15:0] serial_number;
   logic [15:0] packet_total;
   logic [15:0] packet_number;

   modport source (output valid, output event_res, output body_byte, output error_code,
                   output message_id, output message_props, output terminal_id,
                   output serial_number, output packet_total, output packet_number,
                   input ready);
   modport sink   (input valid, input event_res, input body_byte, input error_code,
                   input message_id, input message_props, input terminal_id,
                   input serial_number, input packet_total, input packet_number,
                   output ready);
endinterface

>>> rtl/core/escaped_frame_header_parser_unit.sv
// top level of the escaped frame header parser
// connects input register, frame decoder and result register; uses efhp_pkg, efhp_if

// Takes one raw byte per cycle on the request channel and removes the 0x7e framing and
// 0x7d escapes, checks the xor checksum and captures the 12 or 16 byte header. Each body
// byte, each good frame end and each parse error produces one response that carries the
// header context held at that moment; flags, escape prefixes and header bytes produce
// none. A byte is taken every cycle while responses are drained; each response passes the input
// register and the decode stage into the result register. The rate is set by the single decode
// stage that updates the frame state between the input register and the result register.

module escaped_frame_header_parser_unit (
   input  logic       clock,
   input  logic       reset,
   efhp_req_if.sink   req_if,
   efhp_rsp_if.source rsp_if
);
   import efhp_pkg::*;

   dec_req_type dec_req;
   step_type    step;
   logic        can_take;

   // request byte register
   efhp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .can_take (can_take),
      .dec_req  (dec_req)
   );

   // frame decoder
   efhp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .dec_req (dec_req),
      .step    (step)
   );

   // result register
   efhp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rsp_if   (rsp_if),
      .can_take (can_take)
   );

endmodule

>>> rtl/core/efhp_in_stage.sv
// input register of the escaped frame header parser
// holds one raw request byte until the decoder takes it; uses efhp_pkg, efhp_req_if

module efhp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   efhp_req_if.sink             req_if,
   input  logic                 can_take,
   output efhp_pkg::dec_req_type dec_req
);
   import efhp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       advance;
   logic       accept;

   // byte moves on when the output side has room
   assign advance       = valid_ff & can_take;
   assign req_if.ready  = ~valid_ff | advance;
   assign accept        = req_if.valid & req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request byte
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_if.rx_byte;
      end
   end

   assign dec_req.go      = advance;
   assign dec_req.rx_byte = byte_ff;

endmodule

>>> rtl/core/efhp_decode.sv
// frame decoder of the escaped frame header parser
// flag hunt, unescape, xor checksum, header capture and result selection; uses efhp_pkg

module efhp_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  efhp_pkg::dec_req_type dec_req,
   output efhp_pkg::step_type    step
);
   import efhp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic             esc_ff, esc_in;
   logic             long_ff, long_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [15:0]      id_ff, id_in;
   logic [15:0]      props_ff, props_in;
   logic [47:0]      term_ff, term_in;
   logic [15:0]      serial_ff, serial_in;
   logic [15:0]      total_ff, total_in;
   logic [15:0]      index_ff, index_in;

   logic [7:0]       raw;
   logic [7:0]       ch;
   logic [POS_W-1:0] pos_nx;
   logic [POS_W-1:0] hdr_lim;
   logic [POS_W-1:0] end_pos;
   logic             proceed;
   logic             start;
   logic             do_fail;
   logic [1:0]       fail_code;

   assign raw     = dec_req.rx_byte;
   assign pos_nx  = pos_ff + POS_FIRST;
   assign hdr_lim = long_ff ? HDR_LONG_LIMIT : HDR_SHORT_LIMIT;
   assign end_pos = hdr_lim + {{(POS_W-LEN_W){1'b0}}, len_ff};

   // per-byte decode
   always_comb begin
      pos_in    = pos_ff;
      xor_in    = xor_ff;
      esc_in    = esc_ff;
      long_in   = long_ff;
      len_in    = len_ff;
      id_in     = id_ff;
      props_in  = props_ff;
      term_in   = term_ff;
      serial_in = serial_ff;
      total_in  = total_ff;
      index_in  = index_ff;
      ch        = raw;
      proceed   = 1'b0;
      start     = 1'b0;
      do_fail   = 1'b0;
      fail_code = ERR_ESCAPE;
      step      = '0;

      if (dec_req.go) begin
         if (pos_ff == POS_HUNT) begin
            start = (raw == FLAG_BYTE);
         end else if (pos_ff == POS_FIRST && !esc_ff && raw == FLAG_BYTE) begin
            // repeated opening flag is skipped
            proceed = 1'b0;
         end else begin
            proceed = 1'b1;
            // escape handling
            if (esc_ff) begin
               esc_in = 1'b0;
               if (raw == ESC_CODE_7D) begin
                  ch = ESC_BYTE;
               end else if (raw == ESC_CODE_7E) begin
                  ch = FLAG_BYTE;
               end else begin
                  proceed   = 1'b0;
                  do_fail   = 1'b1;
                  fail_code = ERR_ESCAPE;
               end
            end else if (raw == ESC_BYTE) begin
               esc_in  = 1'b1;
               proceed = 1'b0;
            end

            if (proceed) begin
               xor_in = xor_ff ^ ch;
               pos_in = pos_nx;
               if (pos_nx < hdr_lim) begin
                  // header field capture
                  case (pos_nx)
                     POS_ID_HI:     id_in = {ch, 8'h00};
                     POS_ID_LO:     id_in = {id_ff[15:8], ch};
                     POS_PROPS_HI:  props_in = {ch, 8'h00};
                     POS_PROPS_LO: begin
                        props_in = {props_ff[15:8], ch};
                        len_in   = props_in[LEN_W-1:0] & LEN_MASK[LEN_W-1:0];
                        if ((props_in & ENC_BIT) != '0) begin
                           do_fail   = 1'b1;
                           fail_code = ERR_ENCRYPTED;
                        end else if ((props_in & SPLIT_BIT) != '0) begin
                           long_in = 1'b1;
                        end
                     end
                     POS_TERM_0:    term_in[47:40] = ch;
                     POS_TERM_1:    term_in[39:32] = ch;
                     POS_TERM_2:    term_in[31:24] = ch;
                     POS_TERM_3:    term_in[23:16] = ch;
                     POS_TERM_4:    term_in[15:8]  = ch;
                     POS_TERM_5:    term_in[7:0]   = ch;
                     POS_SERIAL_HI: serial_in = {ch, 8'h00};
                     POS_SERIAL_LO: serial_in = {serial_ff[15:8], ch};
                     POS_TOTAL_HI:  total_in = {ch, 8'h00};
                     POS_TOTAL_LO:  total_in = {total_ff[15:8], ch};
                     POS_INDEX_HI:  index_in = {ch, 8'h00};
                     POS_INDEX_LO:  index_in = {index_ff[15:8], ch};
                     default: ;
                  endcase
               end else if (pos_nx == end_pos) begin
                  // checksum byte closes the frame
                  if (xor_in != 8'h00) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_CHECKSUM;
                  end else begin
                     step.emit              = 1'b1;
                     step.payload.event_res = EV_GOOD;
                     pos_in                 = POS_HUNT;
                  end
               end else begin
                  // body byte passes out
                  step.emit              = 1'b1;
                  step.payload.event_res = EV_BODY;
                  step.payload.body_byte = ch;
               end
            end
         end
      end

      // error ends the frame and rehunts on the same raw byte
      if (do_fail) begin
         step.emit               = 1'b1;
         step.payload.event_res  = EV_ERROR;
         step.payload.error_code = fail_code;
         pos_in                  = POS_HUNT;
         start                   = (raw == FLAG_BYTE);
      end

      // header context as held at this byte
      step.payload.message_id    = id_in;
      step.payload.message_props = props_in;
      step.payload.terminal_id   = term_in;
      step.payload.serial_number = serial_in;
      step.payload.packet_total  = total_in;
      step.payload.packet_number = index_in;

      // opening flag
      if (start) begin
         pos_in   = POS_FIRST;
         xor_in   = 8'h00;
         esc_in   = 1'b0;
         long_in  = 1'b0;
         total_in = 16'h0000;
         index_in = 16'h0000;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HUNT;
         xor_ff    <= 8'h00;
         esc_ff    <= 1'b0;
         long_ff   <= 1'b0;
         len_ff    <= '0;
         id_ff     <= 16'h0000;
         props_ff  <= 16'h0000;
         term_ff   <= 48'h0;
         serial_ff <= 16'h0000;
         total_ff  <= 16'h0000;
         index_ff  <= 16'h0000;
      end else begin
         pos_ff    <= pos_in;
         xor_ff    <= xor_in;
         esc_ff    <= esc_in;
         long_ff   <= long_in;
         len_ff    <= len_in;
         id_ff     <= id_in;
         props_ff  <= props_in;
         term_ff   <= term_in;
         serial_ff <= serial_in;
         total_ff  <= total_in;
         index_ff  <= index_in;
      end
   end

   // a good frame always returns to the hunt
   a_good_ends_frame: assert property (@(posedge clock) disable iff (reset)
      step.emit && step.payload.event_res == EV_GOOD |=> pos_ff == POS_HUNT)
      else $error("good frame did not return to hunt");

   // an error on a raw flag opens the next frame at once
   a_error_flag_reopens: assert property (@(posedge clock) disable iff (reset)
      step.emit && step.payload.event_res == EV_ERROR && raw == FLAG_BYTE
      |=> pos_ff == POS_FIRST && xor_ff == 8'h00)
      else $error("error on flag byte did not reopen frame");

   // body bytes only come after the short header
   a_body_after_header: assert property (@(posedge clock) disable iff (reset)
      step.emit && step.payload.event_res == EV_BODY |-> pos_ff >= POS_SERIAL_LO)
      else $error("body byte inside header");

   // no escape is pending while hunting
   a_no_escape_in_hunt: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_HUNT |-> !esc_ff)
      else $error("escape pending while hunting");

endmodule

>>> rtl/core/efhp_out_stage.sv
// result register of the escaped frame header parser
// holds one result until the response side takes it; uses efhp_pkg, efhp_rsp_if

module efhp_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  efhp_pkg::step_type step,
   efhp_rsp_if.source         rsp_if,
   output logic               can_take
);
   import efhp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   // room when empty or being drained
   assign can_take = ~valid_ff | rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (step.emit) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step.emit) begin
         payload_ff <= step.payload;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.event_res     = payload_ff.event_res;
   assign rsp_if.body_byte     = payload_ff.body_byte;
   assign rsp_if.error_code    = payload_ff.error_code;
   assign rsp_if.message_id    = payload_ff.message_id;
   assign rsp_if.message_props = payload_ff.message_props;
   assign rsp_if.terminal_id   = payload_ff.terminal_id;
   assign rsp_if.serial_number = payload_ff.serial_number;
   assign rsp_if.packet_total  = payload_ff.packet_total;
   assign rsp_if.packet_number = payload_ff.packet_number;

endmodule
